/* design/register_alu_executor_core_macros.svh */
// assertion macros used by the executor core
`ifndef REGISTER_ALU_EXECUTOR_CORE_MACROS_SVH
`define REGISTER_ALU_EXECUTOR_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define RAE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define RAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rae_pkg.sv */
// shared types and constants of the register alu executor
package rae_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 4;
  localparam int IDX_W    = 4;
  localparam int ALU_OP_W = 3;

  // instruction codes
  localparam logic [CMD_W-1:0] CMD_MOVE    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_STORE   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_COMPARE = 4'd3;
  localparam logic [CMD_W-1:0] CMD_BRANCH  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_JUMP    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SUB     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MUL     = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DIV     = 4'd9;

  // serial alu operations
  localparam logic [ALU_OP_W-1:0] ALU_ADD = 3'd0;
  localparam logic [ALU_OP_W-1:0] ALU_SUB = 3'd1;
  localparam logic [ALU_OP_W-1:0] ALU_SLT = 3'd2;
  localparam logic [ALU_OP_W-1:0] ALU_MUL = 3'd3;
  localparam logic [ALU_OP_W-1:0] ALU_DIV = 3'd4;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic                start;
    logic [ALU_OP_W-1:0] op;
  } alu_ctl_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_sts_t;

endpackage

/* design/register_alu_executor_core.sv */
// Register ALU executor: runs one decoded instruction per request against a file of
// REGISTER_COUNT 32-bit registers (all zero after reset). The register file has a
// single read port, so operands and the stored or tested register are fetched one
// after another in the states S_RD_A, S_RD_B and S_RD_C. Add, sub, compare, mul and
// div then run through a bit-serial unit that steps through the operand bits and then
// a fix-up step; move, load, store, branch, jump, undefined codes and a division by
// zero skip the unit. Results sit in an output register, so the next request is
// accepted while a result waits.
module register_alu_executor_core #(
  parameter int REGISTER_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic [3:0]         dest_reg,
  input  logic               first_is_reg,
  input  logic [3:0]         first_index,
  input  logic signed [31:0] first_imm,
  input  logic               second_is_reg,
  input  logic [3:0]         second_index,
  input  logic signed [31:0] second_imm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic signed [31:0] address,
  output logic               div_zero,
  output logic               jump_taken,
  output logic signed [31:0] jump_target
);

`include "register_alu_executor_core_macros.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_A   = 3'd1;
  localparam logic [2:0] S_RD_B   = 3'd2;
  localparam logic [2:0] S_RD_C   = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_ALU    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;

  // captured request
  logic [rae_pkg::CMD_W-1:0] cmd_q;
  logic [rae_pkg::IDX_W-1:0] dest_q;
  logic                      first_is_reg_q;
  logic [rae_pkg::IDX_W-1:0] first_index_q;
  rae_pkg::word_t            first_imm_q;
  logic                      second_is_reg_q;
  logic [rae_pkg::IDX_W-1:0] second_index_q;
  rae_pkg::word_t            second_imm_q;

  // fetched operands
  rae_pkg::word_t op1;
  rae_pkg::word_t op2;
  rae_pkg::word_t rdx;
  rae_pkg::word_t alu_res;

  // register file ports
  logic [rae_pkg::IDX_W-1:0] rd_index;
  rae_pkg::word_t            rd_data;
  logic                      wr_en;
  logic                      wr_sel;
  logic [rae_pkg::IDX_W-1:0] wr_index;
  rae_pkg::word_t            wr_data;

  // alu
  rae_pkg::alu_ctl_t alu_ctl;
  rae_pkg::alu_sts_t alu_sts;
  logic              uses_alu;
  logic              div_by_zero;

  // finished result
  rae_pkg::word_t res_value;
  rae_pkg::word_t res_address;
  logic           res_dz;
  logic           res_taken;
  rae_pkg::word_t res_target;
  logic           out_free;
  logic           finish;

  assign in_ready    = (state == S_IDLE) && !rst;
  assign out_free    = !out_valid || out_ready;
  assign finish      = (state == S_FINISH) && out_free;
  assign div_by_zero = (cmd_q == rae_pkg::CMD_DIV) && (op2 == '0);

  rae_regfile #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .rd_index (rd_index),
    .rd_data  (rd_data)
  );

  rae_serial_alu u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (alu_ctl),
    .a   (op1),
    .b   (op2),
    .sts (alu_sts)
  );

  // read address for each fetch cycle
  always_comb begin
    unique case (state)
      S_RD_A:  rd_index = first_index_q;
      S_RD_B:  rd_index = second_index_q;
      S_RD_C:  rd_index = (cmd_q == rae_pkg::CMD_BRANCH) ? '0 : dest_q;
      default: rd_index = first_index_q;
    endcase
  end

  // alu operation decode
  always_comb begin
    uses_alu   = 1'b1;
    alu_ctl.op = rae_pkg::ALU_ADD;
    unique case (cmd_q)
      rae_pkg::CMD_COMPARE: alu_ctl.op = rae_pkg::ALU_SLT;
      rae_pkg::CMD_ADD:     alu_ctl.op = rae_pkg::ALU_ADD;
      rae_pkg::CMD_SUB:     alu_ctl.op = rae_pkg::ALU_SUB;
      rae_pkg::CMD_MUL:     alu_ctl.op = rae_pkg::ALU_MUL;
      rae_pkg::CMD_DIV:     alu_ctl.op = rae_pkg::ALU_DIV;
      default:              uses_alu   = 1'b0;
    endcase
    alu_ctl.start = (state == S_EXEC) && uses_alu && !div_by_zero;
  end

  // result and write-back decode
  always_comb begin
    res_value   = '0;
    res_address = '0;
    res_dz      = 1'b0;
    res_taken   = 1'b0;
    res_target  = '0;
    wr_sel      = 1'b0;
    wr_index    = '0;
    unique case (cmd_q) inside
      rae_pkg::CMD_MOVE: begin
        res_value = op2;
        wr_sel    = 1'b1;
        wr_index  = dest_q;
      end
      rae_pkg::CMD_LOAD: begin
        res_value   = op2;
        res_address = op2;
        wr_sel      = 1'b1;
        wr_index    = dest_q;
      end
      rae_pkg::CMD_STORE: begin
        res_value   = rdx;
        res_address = op2;
      end
      rae_pkg::CMD_COMPARE, rae_pkg::CMD_ADD, rae_pkg::CMD_SUB, rae_pkg::CMD_MUL: begin
        res_value = alu_res;
        wr_sel    = 1'b1;
      end
      rae_pkg::CMD_DIV: begin
        if (div_by_zero) begin
          res_dz = 1'b1;
        end else begin
          res_value = alu_res;
          wr_sel    = 1'b1;
        end
      end
      rae_pkg::CMD_BRANCH: begin
        if (rdx == 32'd1) begin
          res_taken  = 1'b1;
          res_target = first_imm_q;
        end
      end
      rae_pkg::CMD_JUMP: begin
        res_taken  = 1'b1;
        res_target = first_imm_q;
      end
      default: res_value = '0;
    endcase
  end

  assign wr_en   = finish && wr_sel;
  assign wr_data = res_value;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RD_A;
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: state <= S_RD_C;
        S_RD_C: state <= S_EXEC;
        S_EXEC: state <= alu_ctl.start ? S_ALU : S_FINISH;
        S_ALU: begin
          if (alu_sts.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture and operand fetch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q           <= cmd;
      dest_q          <= dest_reg;
      first_is_reg_q  <= first_is_reg;
      first_index_q   <= first_index;
      first_imm_q     <= first_imm;
      second_is_reg_q <= second_is_reg;
      second_index_q  <= second_index;
      second_imm_q    <= second_imm;
    end
    if (state == S_RD_B) begin
      op1 <= first_is_reg_q ? rd_data : first_imm_q;
    end
    if (state == S_RD_C) begin
      op2 <= second_is_reg_q ? rd_data : second_imm_q;
    end
    if (state == S_EXEC) begin
      rdx <= rd_data;
    end
    if (state == S_ALU && alu_sts.done) begin
      alu_res <= alu_sts.result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      value       <= res_value;
      address     <= res_address;
      div_zero    <= res_dz;
      jump_taken  <= res_taken;
      jump_target <= res_target;
    end
  end

  // checks
  `RAE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `RAE_ASSERT_SAME(a_alu_done_in_wait, alu_sts.done, state == S_ALU, "alu done while not waiting")
  `RAE_ASSERT_SAME(a_div_zero_clean, out_valid && div_zero, value == 0 && !jump_taken, "div zero result not clean")
  `RAE_ASSERT_SAME(a_no_target_untaken, out_valid && !jump_taken, jump_target == 0, "target without jump")

endmodule

/* design/rae_ram.sv */
// generic single write port ram with registered read
module rae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/rae_regfile.sv */
// register file: ram storage, per-entry valid bits and index range check
module rae_regfile #(
  parameter int REGISTER_COUNT = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [rae_pkg::IDX_W-1:0] wr_index,
  input  rae_pkg::word_t           wr_data,
  input  logic [rae_pkg::IDX_W-1:0] rd_index,
  output rae_pkg::word_t           rd_data
);

  localparam int AW = $clog2(REGISTER_COUNT);
  localparam logic [rae_pkg::IDX_W:0] COUNT = (rae_pkg::IDX_W + 1)'(REGISTER_COUNT);

  logic [REGISTER_COUNT-1:0] valid;
  logic                      wr_ok;
  logic                      rd_in_range;
  logic                      rd_ok;
  rae_pkg::word_t            ram_q;

  assign wr_ok       = wr_en && ({1'b0, wr_index} < COUNT);
  assign rd_in_range = {1'b0, rd_index} < COUNT;

  rae_ram #(
    .WIDTH (rae_pkg::DATA_W),
    .DEPTH (REGISTER_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_index[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_index[AW-1:0]),
    .rd_data (ram_q)
  );

  // entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[wr_index[AW-1:0]] <= 1'b1;
      end
      rd_ok <= rd_in_range && valid[rd_index[AW-1:0]];
    end
  end

  assign rd_data = rd_ok ? ram_q : '0;

endmodule

/* design/rae_serial_alu.sv */
// bit-serial alu: add, sub, signed compare, shift-add multiply, restoring divide
module rae_serial_alu (
  input  logic              clk,
  input  logic              rst,
  input  rae_pkg::alu_ctl_t ctl,
  input  rae_pkg::word_t    a,
  input  rae_pkg::word_t    b,
  output rae_pkg::alu_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                   state;
  logic [4:0]                   cnt;
  logic [rae_pkg::ALU_OP_W-1:0] op;
  rae_pkg::word_t               a_sh;
  rae_pkg::word_t               b_sh;
  rae_pkg::word_t               res;
  rae_pkg::word_t               rem;
  logic                         carry;
  logic                         a_sign;
  logic                         b_sign;
  logic                         neg;

  logic                         sum_bit;
  logic                         carry_next;
  logic [32:0]                  shifted;
  logic [33:0]                  trial;
  logic                         lt;

  // one bit of the serial adder
  assign sum_bit    = a_sh[0] ^ b_sh[0] ^ carry;
  assign carry_next = (a_sh[0] & b_sh[0]) | (carry & (a_sh[0] ^ b_sh[0]));

  // one step of the restoring divider
  assign shifted = {rem, a_sh[31]};
  assign trial   = {1'b0, shifted} - {2'b00, b_sh};

  // signed less-than from the sign bits and the difference sign
  assign lt = (a_sign ^ b_sign) ? a_sign : res[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            state <= S_RUN;
            cnt   <= '0;
          end
        end
        S_RUN: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_FIX;
          end
        end
        S_FIX:   state <= S_DONE;
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand shift registers and accumulators
  always_ff @(posedge clk) begin
    if (state == S_IDLE && ctl.start) begin
      op     <= ctl.op;
      a_sign <= a[31];
      b_sign <= b[31];
      neg    <= a[31] ^ b[31];
      res    <= '0;
      rem    <= '0;
      carry  <= (ctl.op == rae_pkg::ALU_SUB) || (ctl.op == rae_pkg::ALU_SLT);
      if (ctl.op == rae_pkg::ALU_DIV) begin
        a_sh <= a[31] ? (32'd0 - a) : a;
        b_sh <= b[31] ? (32'd0 - b) : b;
      end else if ((ctl.op == rae_pkg::ALU_SUB) || (ctl.op == rae_pkg::ALU_SLT)) begin
        a_sh <= a;
        b_sh <= ~b;
      end else begin
        a_sh <= a;
        b_sh <= b;
      end
    end else if (state == S_RUN) begin
      case (op)
        rae_pkg::ALU_MUL: begin
          if (b_sh[0]) begin
            res <= res + a_sh;
          end
          a_sh <= {a_sh[30:0], 1'b0};
          b_sh <= {1'b0, b_sh[31:1]};
        end
        rae_pkg::ALU_DIV: begin
          if (!trial[33]) begin
            rem <= trial[31:0];
          end else begin
            rem <= shifted[31:0];
          end
          res  <= {res[30:0], ~trial[33]};
          a_sh <= {a_sh[30:0], 1'b0};
        end
        default: begin
          res   <= {sum_bit, res[31:1]};
          carry <= carry_next;
          a_sh  <= {1'b0, a_sh[31:1]};
          b_sh  <= {1'b0, b_sh[31:1]};
        end
      endcase
    end else if (state == S_FIX) begin
      case (op)
        rae_pkg::ALU_SLT: res <= {31'd0, lt};
        rae_pkg::ALU_DIV: begin
          if (neg) begin
            res <= 32'd0 - res;
          end
        end
        default: res <= res;
      endcase
    end
  end

  assign sts.done   = (state == S_DONE);
  assign sts.result = res;

endmodule

/* verif/register_alu_executor_core_tb.sv */
// self-checking testbench for the register alu executor core
`timescale 1ns / 1ps

module register_alu_executor_core_tb;

  localparam int REG_COUNT = 10;
  localparam int ITEM_TOTAL = 1250;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int CMD_W = rae_pkg::CMD_W;
  localparam int IDX_W = rae_pkg::IDX_W;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 4'd15;

  typedef rae_pkg::word_t word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] dest;
    logic             first_is_reg;
    logic [IDX_W-1:0] first_index;
    word_t            first_imm;
    logic             second_is_reg;
    logic [IDX_W-1:0] second_index;
    word_t            second_imm;
    logic             hold;
  } instr_t;

  typedef struct packed {
    word_t value;
    word_t address;
    logic  div_zero;
    logic  jump_taken;
    word_t jump_target;
  } exec_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         cmd = '0;
  logic [3:0]         dest_reg = '0;
  logic               first_is_reg = 1'b0;
  logic [3:0]         first_index = '0;
  logic signed [31:0] first_imm = '0;
  logic               second_is_reg = 1'b0;
  logic [3:0]         second_index = '0;
  logic signed [31:0] second_imm = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value;
  logic signed [31:0] address;
  logic               div_zero;
  logic               jump_taken;
  logic signed [31:0] jump_target;

  register_alu_executor_core #(
    .REGISTER_COUNT(REG_COUNT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .dest_reg     (dest_reg),
    .first_is_reg (first_is_reg),
    .first_index  (first_index),
    .first_imm    (first_imm),
    .second_is_reg(second_is_reg),
    .second_index (second_index),
    .second_imm   (second_imm),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .address      (address),
    .div_zero     (div_zero),
    .jump_taken   (jump_taken),
    .jump_target  (jump_target)
  );

  instr_t       pending_requests[$];
  exec_result_t expected_results[$];
  word_t        arch_regs[REG_COUNT];
  int           requests_accepted = 0;
  int           results_checked = 0;
  int           mismatches = 0;
  int           cmd_seen[16];
  int           div_zero_seen = 0;
  int           branches_taken = 0;
  int           holdoffs_done = 0;

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // executor prediction
  // ---------------------------------------------------------------------------

  function automatic word_t reg_read(logic [IDX_W-1:0] idx);
    if (idx < REG_COUNT) return arch_regs[idx];
    return '0;
  endfunction

  function automatic void reg_write(logic [IDX_W-1:0] idx, word_t v);
    if (idx < REG_COUNT) arch_regs[idx] = v;
  endfunction

  function automatic word_t operand_value(logic is_reg, logic [IDX_W-1:0] idx, word_t imm);
    return is_reg ? reg_read(idx) : imm;
  endfunction

  // runs one instruction against the shadow registers, returns its result
  function automatic exec_result_t execute_instr(instr_t i);
    exec_result_t r;
    word_t a, b, mag_a, mag_b, quot;
    r = '0;
    a = operand_value(i.first_is_reg, i.first_index, i.first_imm);
    b = operand_value(i.second_is_reg, i.second_index, i.second_imm);
    case (i.cmd)
      rae_pkg::CMD_MOVE: begin
        reg_write(i.dest, b);
        r.value = b;
      end
      rae_pkg::CMD_LOAD: begin
        reg_write(i.dest, b);
        r.value = b;
        r.address = b;
      end
      rae_pkg::CMD_STORE: begin
        r.value = reg_read(i.dest);
        r.address = b;
      end
      rae_pkg::CMD_COMPARE: begin
        r.value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        arch_regs[0] = r.value;
      end
      rae_pkg::CMD_BRANCH: begin
        if (arch_regs[0] == 32'd1) begin
          r.jump_taken = 1'b1;
          r.jump_target = i.first_imm;
        end
      end
      rae_pkg::CMD_JUMP: begin
        r.jump_taken = 1'b1;
        r.jump_target = i.first_imm;
      end
      rae_pkg::CMD_ADD: begin
        r.value = a + b;
        arch_regs[0] = r.value;
      end
      rae_pkg::CMD_SUB: begin
        r.value = a - b;
        arch_regs[0] = r.value;
      end
      rae_pkg::CMD_MUL: begin
        r.value = a * b;
        arch_regs[0] = r.value;
      end
      rae_pkg::CMD_DIV: begin
        if (b == '0) begin
          r.div_zero = 1'b1;
        end else begin
          // magnitudes divided unsigned, sign put back; min / -1 wraps to min
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          quot = mag_a / mag_b;
          r.value = (a[31] ^ b[31]) ? -quot : quot;
          arch_regs[0] = r.value;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic instr_t request_of(logic [CMD_W-1:0] c, logic [IDX_W-1:0] d,
                                        logic fr, logic [IDX_W-1:0] fi, word_t fv,
                                        logic sr, logic [IDX_W-1:0] si, word_t sv);
    instr_t r;
    r.cmd = c;
    r.dest = d;
    r.first_is_reg = fr;
    r.first_index = fi;
    r.first_imm = fv;
    r.second_is_reg = sr;
    r.second_index = si;
    r.second_imm = sv;
    r.hold = 1'b0;
    return r;
  endfunction

  // mostly valid register numbers, sometimes past the end of the file
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 6) == 0) return IDX_W'($urandom_range(REG_COUNT, 15));
    return IDX_W'($urandom_range(0, REG_COUNT - 1));
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 5: return word_t'($urandom_range(0, 8)) - 32'd4;
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0000;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic instr_t random_request();
    logic [CMD_W-1:0] c;
    if ($urandom_range(0, 9) == 0)
      c = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    else
      c = CMD_W'($urandom_range(rae_pkg::CMD_MOVE, rae_pkg::CMD_DIV));
    return request_of(c, pick_index(), 1'($urandom_range(0, 1)), pick_index(), pick_word(),
                      1'($urandom_range(0, 1)), pick_index(), pick_word());
  endfunction

  // every few hundred requests the sender waits for the block to drain first
  task automatic push_request(instr_t r);
    r.hold = (pending_requests.size() % 300 == 25);
    pending_requests.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_requests
    instr_t nxt;
    logic   offer;
    int     burst_left;
    int     gap_left;
    int     in_flight;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      in_flight = 0;
    end else begin
      if (in_valid && in_ready) in_flight++;
      if (out_valid && out_ready) in_flight--;
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0)
          gap_left--;
        else if (pending_requests.size() != 0)
          offer = !(pending_requests[0].hold && in_flight != 0);
        if (offer) begin
          nxt = pending_requests.pop_front();
          cmd <= nxt.cmd;
          dest_reg <= nxt.dest;
          first_is_reg <= nxt.first_is_reg;
          first_index <= nxt.first_index;
          first_imm <= nxt.first_imm;
          second_is_reg <= nxt.second_is_reg;
          second_index <= nxt.second_index;
          second_imm <= nxt.second_imm;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: changing stall pattern plus periodic long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : accept_results
    rx_mode_t mode;
    int       mode_left;
    int       holdoff_left;
    int       rx_cycle;
    if (rst) begin
      out_ready <= 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      holdoff_left = 0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle % 9000 == 1500) begin
        // long hold-off so the block fills and backs up its input
        holdoff_left = HOLDOFF_CYCLES;
        holdoffs_done++;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_OPEN:    out_ready <= 1'b1;
          RX_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
          RX_PATTERN: out_ready <= (rx_cycle % 5 < 2);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted request, checks each accepted result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    instr_t       req;
    exec_result_t want;
    exec_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        req = request_of(cmd, dest_reg, first_is_reg, first_index, first_imm,
                         second_is_reg, second_index, second_imm);
        want = execute_instr(req);
        expected_results.push_back(want);
        requests_accepted++;
        cmd_seen[cmd]++;
        if (want.div_zero) div_zero_seen++;
        if (req.cmd == rae_pkg::CMD_BRANCH && want.jump_taken) branches_taken++;
      end
      if (out_valid && out_ready) begin
        got.value = value;
        got.address = address;
        got.div_zero = div_zero;
        got.jump_taken = jump_taken;
        got.jump_target = jump_target;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result with no request outstanding: value=%h address=%h", value, address);
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value || got.address !== want.address ||
              got.div_zero !== want.div_zero || got.jump_taken !== want.jump_taken ||
              got.jump_target !== want.jump_target) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected value=%h addr=%h dz=%b jt=%b tgt=%h",
                       results_checked, want.value, want.address, want.div_zero,
                       want.jump_taken, want.jump_target,
                       ", got value=%h addr=%h dz=%b jt=%b tgt=%h",
                       got.value, got.address, got.div_zero, got.jump_taken,
                       got.jump_target);
          end
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake ends the run
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: %0d cycles with no request or result moving", IDLE_LIMIT);
        $display("register_alu_executor_core: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : run_test
    instr_t r;
    instr_t follow;
    int     total;
    for (int k = 0; k < REG_COUNT; k++) arch_regs[k] = '0;
    for (int k = 0; k < 16; k++) cmd_seen[k] = 0;

    // directed: extremes, every command, out-of-range registers, division corners
    push_request(request_of(rae_pkg::CMD_LOAD, 4'd1, 1'b0, 4'd0, '0, 1'b0, 4'd0,
                            32'h7fff_ffff));
    push_request(request_of(rae_pkg::CMD_LOAD, 4'd2, 1'b0, 4'd0, '0, 1'b0, 4'd0,
                            32'h8000_0000));
    push_request(request_of(rae_pkg::CMD_MOVE, 4'd3, 1'b0, 4'd0, '0, 1'b0, 4'd0,
                            32'hffff_ffff));
    push_request(request_of(rae_pkg::CMD_MOVE, 4'd4, 1'b0, 4'd0, '0, 1'b1, 4'd1,
                            32'h5555_aaaa));
    push_request(request_of(rae_pkg::CMD_STORE, 4'd2, 1'b0, 4'd0, '0, 1'b0, 4'd0,
                            32'h1234_5678));
    push_request(request_of(rae_pkg::CMD_STORE, 4'd12, 1'b1, 4'd13, '1, 1'b1, 4'd15,
                            32'hdead_beef));
    push_request(request_of(rae_pkg::CMD_LOAD, 4'd15, 1'b0, 4'd0, '0, 1'b0, 4'd0, 32'd5));
    push_request(request_of(rae_pkg::CMD_ADD, 4'd0, 1'b1, 4'd1, '0, 1'b0, 4'd0, 32'd1));
    push_request(request_of(rae_pkg::CMD_SUB, 4'd0, 1'b1, 4'd2, '0, 1'b0, 4'd0, 32'd1));
    push_request(request_of(rae_pkg::CMD_MUL, 4'd0, 1'b1, 4'd1, '0, 1'b1, 4'd1, '0));
    push_request(request_of(rae_pkg::CMD_COMPARE, 4'd0, 1'b1, 4'd2, '0, 1'b1, 4'd1, '0));
    push_request(request_of(rae_pkg::CMD_BRANCH, 4'd0, 1'b1, 4'd3, 32'h7fff_ffff,
                            1'b0, 4'd0, '0));
    push_request(request_of(rae_pkg::CMD_COMPARE, 4'd0, 1'b1, 4'd1, '0, 1'b1, 4'd2, '0));
    push_request(request_of(rae_pkg::CMD_BRANCH, 4'd0, 1'b0, 4'd0, 32'h8000_0000,
                            1'b0, 4'd0, '0));
    push_request(request_of(rae_pkg::CMD_JUMP, 4'd9, 1'b1, 4'd9, 32'h8000_0000,
                            1'b1, 4'd9, '1));
    push_request(request_of(rae_pkg::CMD_DIV, 4'd0, 1'b1, 4'd2, '0, 1'b0, 4'd0,
                            32'hffff_ffff));
    push_request(request_of(rae_pkg::CMD_DIV, 4'd0, 1'b0, 4'd0, 32'd7, 1'b0, 4'd0, 32'd0));
    push_request(request_of(rae_pkg::CMD_DIV, 4'd0, 1'b0, 4'd0, -32'sd7, 1'b0, 4'd0,
                            32'd2));
    push_request(request_of(rae_pkg::CMD_DIV, 4'd0, 1'b0, 4'd0, 32'd7, 1'b0, 4'd0,
                            -32'sd2));
    push_request(request_of(rae_pkg::CMD_DIV, 4'd0, 1'b1, 4'd3, '0, 1'b1, 4'd14, '1));
    push_request(request_of(rae_pkg::CMD_MUL, 4'd0, 1'b0, 4'd0, 32'h8000_0000,
                            1'b0, 4'd0, '1));
    push_request(request_of(CMD_UNDEF_LO, 4'd1, 1'b1, 4'd2, '1, 1'b1, 4'd3, '1));
    push_request(request_of(CMD_UNDEF_HI, 4'hf, 1'b1, 4'hf, '1, 1'b1, 4'hf, '1));
    push_request(request_of(rae_pkg::CMD_MOVE, 4'd0, 1'b0, 4'd0, '0, 1'b0, 4'd0, 32'd1));
    push_request(request_of(rae_pkg::CMD_BRANCH, 4'd0, 1'b0, 4'd0, 32'h0000_0040,
                            1'b0, 4'd0, '0));

    // random: mostly loose requests, compare-then-branch and load-then-compare..div pairs
    while (pending_requests.size() < ITEM_TOTAL) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = random_request();
          r.cmd = rae_pkg::CMD_COMPARE;
          follow = random_request();
          follow.cmd = rae_pkg::CMD_BRANCH;
          push_request(r);
          push_request(follow);
        end
        2: begin
          r = random_request();
          r.cmd = rae_pkg::CMD_LOAD;
          r.dest = IDX_W'($urandom_range(0, REG_COUNT - 1));
          follow = random_request();
          follow.cmd = CMD_W'($urandom_range(rae_pkg::CMD_COMPARE, rae_pkg::CMD_DIV));
          follow.first_is_reg = 1'b1;
          follow.first_index = r.dest;
          push_request(r);
          push_request(follow);
        end
        default: push_request(random_request());
      endcase
    end
    total = pending_requests.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to go in and every result to come back
    while (requests_accepted < total || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("ran %0d requests, checked %0d results, %0d long output hold-offs",
             requests_accepted, results_checked, holdoffs_done,
             ", %0d divides by zero, %0d branches taken", div_zero_seen, branches_taken);
    $display("commands mv %0d ld %0d st %0d cmp %0d br %0d jmp %0d",
             cmd_seen[rae_pkg::CMD_MOVE], cmd_seen[rae_pkg::CMD_LOAD],
             cmd_seen[rae_pkg::CMD_STORE], cmd_seen[rae_pkg::CMD_COMPARE],
             cmd_seen[rae_pkg::CMD_BRANCH], cmd_seen[rae_pkg::CMD_JUMP],
             " add %0d sub %0d mul %0d div %0d",
             cmd_seen[rae_pkg::CMD_ADD], cmd_seen[rae_pkg::CMD_SUB],
             cmd_seen[rae_pkg::CMD_MUL], cmd_seen[rae_pkg::CMD_DIV]);

    if (mismatches == 0)
      $display("register_alu_executor_core: match");
    else
      $display("register_alu_executor_core: mismatch");
    $finish;
  end

endmodule
